/* hdl/i2c_target_register_map_handler_unit_macros.svh */
// Assertion macros shared by the handler RTL
`ifndef I2C_TARGET_REGISTER_MAP_HANDLER_UNIT_MACROS_SVH
`define I2C_TARGET_REGISTER_MAP_HANDLER_UNIT_MACROS_SVH

// invariant checked at every clock edge out of reset
`define I2CRM_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// implication checked in the same cycle
`define I2CRM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* hdl/i2crm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package i2crm_pkg;

	localparam int RX_DEPTH    = 32;
	localparam int TABLE_DEPTH = 128;
	localparam int POWER_LEN   = 16;

	localparam int RX_AW  = $clog2(RX_DEPTH);
	localparam int RXC_W  = $clog2(RX_DEPTH + 1);
	localparam int TBL_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int PWR_AW = $clog2(POWER_LEN);

	localparam logic [7:0] VERSION_OFFSET = 8'hC0;
	localparam logic [7:0] POWER_WINDOW   = 8'hF0;
	localparam logic [7:0] ISP_MAGIC_HEAD = 8'h4E;
	localparam logic [7:0] PWR_MAGIC_HEAD = 8'hDC;
	localparam logic [2:0] POWER_MAGIC_LEN = 3'd5;
	localparam logic [2:0] ISP_MAGIC_LEN   = 3'd7;

	localparam logic [0:0] CFG_FIRMWARE_VERSION  = 1'b0;
	localparam logic [0:0] CFG_POWER_READ_OFFSET = 1'b1;

	typedef enum logic [3:0] {
		CMD_ADDR_WRITE = 4'd0,
		CMD_DATA_RX    = 4'd1,
		CMD_DATA_NACK  = 4'd2,
		CMD_ADDR_READ  = 4'd3,
		CMD_SENT_ACK   = 4'd4,
		CMD_SENT_NACK  = 4'd5,
		CMD_STOP       = 4'd6,
		CMD_ARB_LOST   = 4'd7,
		CMD_BUS_ERR    = 4'd8,
		CMD_TIMEOUT    = 4'd9,
		CMD_LOAD_TABLE = 4'd10,
		CMD_LOAD_POWER = 4'd11
	} cmd_t;

	typedef enum logic [1:0] {
		ACT_ACK     = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_REINIT  = 2'd2
	} bus_action_t;

	typedef enum logic [1:0] {
		PM_OFF   = 2'd0,
		PM_ARMED = 2'd1,
		PM_READ  = 2'd2
	} pwr_mode_t;

	typedef enum logic [1:0] {
		MODE_NONE  = 2'd0,
		MODE_TABLE = 2'd1,
		MODE_ARMED = 2'd2,
		MODE_POWER = 2'd3
	} report_mode_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_TRD  = 4'b0010,
		ST_DEC  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	typedef struct packed {
		report_mode_t report_mode;
		logic         isp_request;
		bus_action_t  bus_action;
		logic         tx_valid;
		logic [7:0]   tx_byte;
	} result_t;

	function automatic logic [7:0] magic_byte(input logic isp, input logic [2:0] idx);
		logic [7:0] b;
		b = 8'h00;
		if (isp) begin
			case (idx)
				3'd0: b = 8'h4E;
				3'd1: b = 8'h05;
				3'd2: b = 8'h4A;
				3'd3: b = 8'h4D;
				3'd4: b = 8'h50;
				3'd5: b = 8'h4C;
				3'd6: b = 8'h44;
				default: b = 8'h00;
			endcase
		end else begin
			case (idx)
				3'd0: b = 8'hDC;
				3'd1: b = 8'h03;
				3'd2: b = 8'h07;
				3'd3: b = 8'h80;
				default: b = 8'h00;
			endcase
		end
		return b;
	endfunction

	function automatic logic [7:0] power_reset(input logic [PWR_AW-1:0] idx);
		logic [7:0] b;
		case (idx)
			PWR_AW'(0): b = 8'h0F;
			PWR_AW'(1): b = 8'h07;
			PWR_AW'(2): b = 8'h1F;
			default:    b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

/* hdl/i2c_target_register_map_handler_unit.sv */
// An item is accepted in ST_IDLE and passes through ST_FIN into the output register; a table read
// goes through ST_TRD first, which waits on the table RAM. A stop goes through ST_DEC, where for a
// buffered write of 1, 5 or 7 bytes the receive RAM is read one byte a cycle for the magic compare.
// Only one item is handled at a time; the next item is taken once the result moves to the output
// register, which ST_FIN holds off while the output register is full and not taken.
// Reset: arst_n clears modes, pointer, counts, table valid bits and loads the power header.
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_target_register_map_handler_unit_macros.svh"

module i2c_target_register_map_handler_unit
	import i2crm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // data_byte [7:0], load_index [15:8]
	input  wire logic [3:0]  s_axis_tuser,   // command [3:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [15:0] m_axis_tdata,   // tx_byte, tx_valid, bus_action, isp_request,
	                                         // report_mode, zero fill
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [7:0]  cfg_wdata
);

	state_t                 state_q;
	logic [7:0]             fw_q;
	logic [7:0]             poff_q;
	logic [RXC_W-1:0]       rxc_q;
	logic [7:0]             ptr_q;
	logic                   tm_q;
	pwr_mode_t              pm_q;
	logic                   isp_q;
	logic [TABLE_DEPTH-1:0] tvld_q;
	logic [7:0]             pwr_q [POWER_LEN];
	logic [2:0]             dec_k_q;
	logic                   dec_v_s1;
	logic [2:0]             dec_i_s1;
	logic                   dec_match_q;
	logic [7:0]             dec_b0_q;
	logic [7:0]             res_tx_q;
	logic                   res_valid_q;
	bus_action_t            res_act_q;
	result_t                out_q;
	logic                   out_v_q;

	logic       acc;
	cmd_t       cmd;
	logic [7:0] din;
	logic [7:0] idx;
	logic       rx_we;
	logic [7:0] rx_rdata;
	logic       tbl_we;
	logic [7:0] tbl_rdata;
	logic [2:0] dec_len;
	logic       isp_sel;
	logic       rd_tbl;
	logic [7:0] rd_val;
	logic       rd_adv;
	logic       single_ok;
	logic       is_read;
	bus_action_t act_d;
	report_mode_t mode_now;

	assign acc = s_axis_tvalid && s_axis_tready;
	assign cmd = cmd_t'(s_axis_tuser);
	assign din = s_axis_tdata[7:0];
	assign idx = s_axis_tdata[15:8];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {2'b00, out_q};

	assign rx_we  = acc && (cmd == CMD_DATA_RX) && (rxc_q < RXC_W'(RX_DEPTH));
	assign tbl_we = acc && (cmd == CMD_LOAD_TABLE) && ({1'b0, idx} < 9'(TABLE_DEPTH));

	assign is_read = (cmd == CMD_ADDR_READ) || (cmd == CMD_SENT_ACK);

	always_comb begin
		case (cmd)
			CMD_TIMEOUT: act_d = ACT_REINIT;
			CMD_ADDR_WRITE, CMD_DATA_RX, CMD_DATA_NACK, CMD_ADDR_READ, CMD_SENT_ACK,
			CMD_SENT_NACK, CMD_STOP, CMD_ARB_LOST, CMD_LOAD_TABLE, CMD_LOAD_POWER:
				act_d = ACT_ACK;
			default: act_d = ACT_RELEASE;
		endcase
	end

	i2crm_ram #(
		.WIDTH (8),
		.DEPTH (RX_DEPTH)
	) u_rx_ram (
		.clk   (clk),
		.we    (rx_we),
		.waddr (rxc_q[RX_AW-1:0]),
		.wdata (din),
		.raddr (RX_AW'(dec_k_q)),
		.rdata (rx_rdata)
	);

	i2crm_ram #(
		.WIDTH (8),
		.DEPTH (TABLE_DEPTH)
	) u_tbl_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (idx[TBL_AW-1:0]),
		.wdata (din),
		.raddr (ptr_q[TBL_AW-1:0]),
		.rdata (tbl_rdata)
	);

	always_comb begin
		dec_len = 3'd0;
		if (rxc_q == RXC_W'(ISP_MAGIC_LEN)) begin
			dec_len = ISP_MAGIC_LEN;
		end else if (rxc_q == RXC_W'(POWER_MAGIC_LEN)) begin
			dec_len = POWER_MAGIC_LEN;
		end else if (rxc_q == RXC_W'(1)) begin
			dec_len = 3'd1;
		end
	end

	assign isp_sel = (rxc_q == RXC_W'(ISP_MAGIC_LEN));
	assign rd_tbl  = tm_q && ({1'b0, ptr_q} < 9'(TABLE_DEPTH));

	always_comb begin
		rd_val = 8'h00;
		rd_adv = 1'b0;
		if (tm_q) begin
			if (ptr_q == VERSION_OFFSET) begin
				rd_val = fw_q;
			end else if (ptr_q >= POWER_WINDOW) begin
				rd_val = pwr_q[ptr_q[PWR_AW-1:0]];
				rd_adv = 1'b1;
			end
		end else if (pm_q == PM_READ && ({1'b0, ptr_q} < 9'(POWER_LEN))) begin
			rd_val = pwr_q[ptr_q[PWR_AW-1:0]];
			rd_adv = 1'b1;
		end
	end

	assign single_ok = (rxc_q == RXC_W'(1)) && (({1'b0, dec_b0_q} < 9'(TABLE_DEPTH))
		|| dec_b0_q == VERSION_OFFSET || dec_b0_q >= POWER_WINDOW);

	always_comb begin
		if (tm_q) begin
			mode_now = MODE_TABLE;
		end else if (pm_q == PM_ARMED) begin
			mode_now = MODE_ARMED;
		end else if (pm_q == PM_READ) begin
			mode_now = MODE_POWER;
		end else begin
			mode_now = MODE_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fw_q        <= 8'd8;
			poff_q      <= 8'd0;
			rxc_q       <= '0;
			ptr_q       <= 8'd0;
			tm_q        <= 1'b0;
			pm_q        <= PM_OFF;
			isp_q       <= 1'b0;
			tvld_q      <= '0;
			for (int i = 0; i < POWER_LEN; i++) begin
				pwr_q[i] <= power_reset(PWR_AW'(i));
			end
			dec_k_q     <= 3'd0;
			dec_v_s1    <= 1'b0;
			dec_i_s1    <= 3'd0;
			dec_match_q <= 1'b0;
			dec_b0_q    <= 8'd0;
			res_tx_q    <= 8'd0;
			res_valid_q <= 1'b0;
			res_act_q   <= ACT_ACK;
			out_q       <= '0;
			out_v_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FIRMWARE_VERSION:  fw_q   <= cfg_wdata;
					CFG_POWER_READ_OFFSET: poff_q <= cfg_wdata;
					default: ;
				endcase
			end

			if (m_axis_tvalid && m_axis_tready && state_q != ST_FIN) begin
				out_v_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						res_tx_q    <= (is_read && !rd_tbl) ? rd_val : 8'h00;
						res_valid_q <= is_read;
						res_act_q   <= act_d;
						if (is_read && rd_tbl) begin
							state_q <= ST_TRD;
						end else if (cmd == CMD_STOP) begin
							state_q <= ST_DEC;
						end else begin
							state_q <= ST_FIN;
						end
						case (cmd)
							CMD_ADDR_WRITE, CMD_DATA_NACK: begin
								rxc_q <= '0;
							end
							CMD_DATA_RX: begin
								if (rx_we) begin
									rxc_q <= rxc_q + RXC_W'(1);
								end
							end
							CMD_ADDR_READ, CMD_SENT_ACK: begin
								if (!rd_tbl && rd_adv) begin
									ptr_q <= ptr_q + 8'd1;
								end
							end
							CMD_SENT_NACK: begin
								tm_q <= 1'b0;
								pm_q <= PM_OFF;
							end
							CMD_STOP: begin
								dec_k_q     <= 3'd0;
								dec_v_s1    <= 1'b0;
								dec_match_q <= 1'b1;
							end
							CMD_ARB_LOST: ;
							CMD_LOAD_TABLE: begin
								if (tbl_we) begin
									tvld_q[idx[TBL_AW-1:0]] <= 1'b1;
								end
							end
							CMD_LOAD_POWER: begin
								if ({1'b0, idx} < 9'(POWER_LEN)) begin
									pwr_q[idx[PWR_AW-1:0]] <= din;
								end
							end
							default: ;
						endcase
					end
				end

				ST_TRD: begin
					res_tx_q <= tvld_q[ptr_q[TBL_AW-1:0]] ? tbl_rdata : 8'h00;
					ptr_q    <= ptr_q + 8'd1;
					state_q  <= ST_FIN;
				end

				ST_DEC: begin
					if (dec_k_q < dec_len) begin
						dec_v_s1 <= 1'b1;
						dec_i_s1 <= dec_k_q;
						dec_k_q  <= dec_k_q + 3'd1;
					end else begin
						dec_v_s1 <= 1'b0;
					end
					if (dec_v_s1) begin
						if (rx_rdata != magic_byte(isp_sel, dec_i_s1)) begin
							dec_match_q <= 1'b0;
						end
						if (dec_i_s1 == 3'd0) begin
							dec_b0_q <= rx_rdata;
						end
					end
					if (dec_k_q == dec_len && !dec_v_s1) begin
						if (single_ok) begin
							ptr_q <= dec_b0_q;
							tm_q  <= 1'b1;
							pm_q  <= PM_OFF;
						end else if (isp_sel && dec_b0_q == ISP_MAGIC_HEAD) begin
							if (dec_match_q) begin
								isp_q <= 1'b1;
							end
							tm_q <= 1'b0;
						end else if (rxc_q == RXC_W'(POWER_MAGIC_LEN)
							&& dec_b0_q == PWR_MAGIC_HEAD) begin
							if (dec_match_q) begin
								ptr_q <= 8'd0;
								pm_q  <= PM_ARMED;
							end
							tm_q <= 1'b0;
						end else if (pm_q == PM_ARMED && rxc_q == RXC_W'(1)
							&& dec_b0_q == poff_q) begin
							ptr_q <= 8'd0;
							pm_q  <= PM_READ;
							tm_q  <= 1'b0;
						end else begin
							tm_q <= 1'b0;
							pm_q <= PM_OFF;
						end
						rxc_q   <= '0;
						state_q <= ST_FIN;
					end
				end

				ST_FIN: begin
					if (!out_v_q || m_axis_tready) begin
						out_q.tx_byte     <= res_tx_q;
						out_q.tx_valid    <= res_valid_q;
						out_q.bus_action  <= res_act_q;
						out_q.isp_request <= isp_q;
						out_q.report_mode <= mode_now;
						out_v_q           <= 1'b1;
						state_q           <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`I2CRM_ASSERT_ALWAYS(a_rxc_range, rxc_q <= RXC_W'(RX_DEPTH), "rx count past buffer depth")
	`I2CRM_ASSERT_IMP(a_mode_excl, tm_q, pm_q == PM_OFF, "table and power mode both set")
	`I2CRM_ASSERT_ALWAYS(a_pm_code, pm_q != pwr_mode_t'(2'd3), "power mode holds unused code")
	`I2CRM_ASSERT_IMP(a_dec_bound, state_q == ST_DEC, dec_k_q <= dec_len, "decode index overrun")
	`I2CRM_ASSERT_IMP(a_tx_zero, m_axis_tvalid && !m_axis_tdata[8], m_axis_tdata[7:0] == 8'h00,
		"tx byte set on a non-read item")

endmodule

`default_nettype wire

/* hdl/i2crm_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module i2crm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire
